// ===== sv/sparc_subset_core_assert.svh =====
// ----------------------------------------------------------------------------
// sparc_subset_core assertion macros
// immediate-consequence and next-cycle implication checks on a clock and reset
// ----------------------------------------------------------------------------
`ifndef SPARC_SUBSET_CORE_ASSERT_SVH
`define SPARC_SUBSET_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// request codes, instruction encodings and result kinds of the subset core
// ----------------------------------------------------------------------------
package ssc_pkg;

   typedef logic [31:0] word_type;

   // request codes
   localparam logic [1:0] REQ_WRITE_MEM = 2'd0;
   localparam logic [1:0] REQ_READ_MEM  = 2'd1;
   localparam logic [1:0] REQ_READ_REG  = 2'd2;
   localparam logic [1:0] REQ_STEP      = 2'd3;

   // instruction word fields
   localparam logic [9:0] OP2_BA     = 10'h042;
   localparam logic [9:0] OP2_BGE    = 10'h05a;
   localparam logic [1:0] FMT_SETHI  = 2'b00;
   localparam logic [2:0] SUB_SETHI  = 3'b100;
   localparam logic [1:0] FMT_ALU    = 2'b10;
   localparam logic [1:0] FMT_MEM    = 2'b11;
   localparam logic [5:0] OP3_ADD    = 6'h00;
   localparam logic [5:0] OP3_OR     = 6'h02;
   localparam logic [5:0] OP3_SUB    = 6'h04;
   localparam logic [5:0] OP3_SUBCC  = 6'h14;
   localparam logic [5:0] OP3_SLL    = 6'h25;
   localparam logic [5:0] OP3_LOAD   = 6'h00;
   localparam logic [5:0] OP3_STORE  = 6'h04;

   // result kinds
   localparam logic [3:0] KIND_NONE      = 4'd0;
   localparam logic [3:0] KIND_BA        = 4'd0;
   localparam logic [3:0] KIND_BGE_NOT   = 4'd1;
   localparam logic [3:0] KIND_BGE_TAKEN = 4'd2;
   localparam logic [3:0] KIND_SETHI     = 4'd3;
   localparam logic [3:0] KIND_ADD       = 4'd4;
   localparam logic [3:0] KIND_OR        = 4'd5;
   localparam logic [3:0] KIND_SUB       = 4'd6;
   localparam logic [3:0] KIND_SUBCC     = 4'd7;
   localparam logic [3:0] KIND_SLL       = 4'd8;
   localparam logic [3:0] KIND_LOAD      = 4'd9;
   localparam logic [3:0] KIND_STORE     = 4'd10;
   localparam logic [3:0] KIND_HALT      = 4'd11;

endpackage

// ===== sv/sparc_subset_core.sv =====
// ----------------------------------------------------------------------------
// sparc_subset_core: a memory write or a step while halted strobes straight from idle;
// memory and register reads pass ST_MRD or ST_RRD; branches, sethi and halt pass ST_FETCH,
// alu steps pass ST_FETCH and ST_EXEC, load and store also ST_LOAD or ST_STRD; a new
// transaction is taken in the strobe cycle, as the memory ports and register file read
// ports serialize each step; after reset busy stays high while the memory is swept to zero
// ----------------------------------------------------------------------------
module sparc_subset_core
   import ssc_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_word_addr,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic [11:0] rsp_next_pc,
   output logic [3:0]  rsp_cond_codes,
   output logic [3:0]  rsp_instr_kind,
   output logic        rsp_halted
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MRD, ST_RRD, ST_FETCH, ST_EXEC, ST_LOAD, ST_STRD
   } state_type;

   // memories
   word_type        ram_ff [MEM_WORDS];
   word_type        rf_ff  [32];

   // registers
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]   pc_ff, pc_in;
   logic [3:0]      cc_ff, cc_in;
   logic            halt_ff, halt_in;
   word_type        ir_ff, ir_in;
   logic [AW-1:0]   ea_ff, ea_in;
   logic [31:0]     rf_vld_ff, rf_vld_in;
   logic            rsp_valid_ff, rsp_valid_in;
   word_type        rsp_data_ff, rsp_data_in;
   logic [3:0]      rsp_kind_ff, rsp_kind_in;
   word_type        ram_rdata_ff;
   word_type        rfa_ff, rfb_ff;
   logic            rfa_vld_ff, rfb_vld_ff;

   // memory controls
   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   word_type        ram_wdata;
   logic            rf_we;
   logic [4:0]      rf_waddr, rf_ra, rf_rb;
   word_type        rf_wdata;

   // datapath
   logic            accept;
   logic [31:0]     req_addr32;
   logic [31:0]     pc32;
   word_type        ir_w;
   logic [AW-1:0]   pc1;
   logic [31:0]     disp32, tgt_sum;
   logic [AW-1:0]   tgt;
   logic [5:0]      op3_w;
   logic            op_ok;
   word_type        op_a, op_b, simm, sum, diff, res;
   logic            ovf;

   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign req_addr32     = 32'(req_word_addr);
   assign pc32           = 32'(pc_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_next_pc    = pc32[11:0];
   assign rsp_cond_codes = cc_ff;
   assign rsp_instr_kind = rsp_kind_ff;
   assign rsp_halted     = halt_ff;

   // fetch decode
   assign ir_w    = ram_rdata_ff;
   assign pc1     = pc_ff + AW'(1);
   assign disp32  = {{10{ir_w[21]}}, ir_w[21:0]};
   assign tgt_sum = 32'(pc1) + disp32;
   assign tgt     = tgt_sum[AW-1:0];
   assign op3_w   = ir_w[24:19];
   assign op_ok   = ((ir_w[31:30] == FMT_ALU) && ((op3_w == OP3_ADD) || (op3_w == OP3_OR) ||
                     (op3_w == OP3_SUB) || (op3_w == OP3_SUBCC) || (op3_w == OP3_SLL))) ||
                    ((ir_w[31:30] == FMT_MEM) && ((op3_w == OP3_LOAD) ||
                     (op3_w == OP3_STORE)));

   // execute operands
   assign simm = {{19{ir_ff[12]}}, ir_ff[12:0]};
   assign op_a = rfa_vld_ff ? rfa_ff : '0;
   assign op_b = ir_ff[13] ? simm : (rfb_vld_ff ? rfb_ff : '0);
   assign sum  = op_a + op_b;
   assign diff = op_a - op_b;
   assign ovf  = ((op_a[31] ^ op_b[31]) & (op_a[31] ^ diff[31]));

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pc_in        = pc_ff;
      cc_in        = cc_ff;
      halt_in      = halt_ff;
      ir_in        = ir_ff;
      ea_in        = ea_ff;
      rf_vld_in    = rf_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_cnt_ff;
      ram_wdata    = '0;
      ram_raddr    = pc_ff;
      rf_we        = 1'b0;
      rf_waddr     = ir_ff[29:25];
      rf_wdata     = '0;
      rf_ra        = ir_ff[18:14];
      rf_rb        = ir_ff[4:0];
      res          = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_WRITE_MEM: begin
                     ram_we       = 1'b1;
                     ram_waddr    = req_addr32[AW-1:0];
                     ram_wdata    = req_write_data;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_kind_in  = KIND_NONE;
                  end
                  REQ_READ_MEM: begin
                     ram_raddr = req_addr32[AW-1:0];
                     state_in  = ST_MRD;
                  end
                  REQ_READ_REG: begin
                     rf_ra    = req_word_addr[4:0];
                     state_in = ST_RRD;
                  end
                  default: begin
                     if (halt_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_kind_in  = KIND_HALT;
                     end else begin
                        ram_raddr = pc_ff;
                        state_in  = ST_FETCH;
                     end
                  end
               endcase
            end
         end
         ST_MRD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rdata_ff;
            rsp_kind_in  = KIND_NONE;
            state_in     = ST_IDLE;
         end
         ST_RRD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = op_a;
            rsp_kind_in  = KIND_NONE;
            state_in     = ST_IDLE;
         end
         ST_FETCH: begin
            ir_in        = ir_w;
            pc_in        = pc1;
            rsp_data_in  = '0;
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (ir_w[31:22] == OP2_BA) begin
               pc_in       = tgt;
               rsp_kind_in = KIND_BA;
            end else if (ir_w[31:22] == OP2_BGE) begin
               if ((cc_ff[3] ^ cc_ff[1]) == 1'b0) begin
                  pc_in       = tgt;
                  rsp_kind_in = KIND_BGE_TAKEN;
               end else begin
                  rsp_kind_in = KIND_BGE_NOT;
               end
            end else if ((ir_w[31:30] == FMT_SETHI) && (ir_w[24:22] == SUB_SETHI)) begin
               rf_we       = (ir_w[29:25] != 5'd0);
               rf_waddr    = ir_w[29:25];
               rf_wdata    = {ir_w[21:0], 10'd0};
               rsp_data_in = {ir_w[21:0], 10'd0};
               rsp_kind_in = KIND_SETHI;
            end else if (op_ok) begin
               rf_ra        = ir_w[18:14];
               rf_rb        = ir_w[4:0];
               rsp_valid_in = 1'b0;
               state_in     = ST_EXEC;
            end else begin
               halt_in     = 1'b1;
               rsp_kind_in = KIND_HALT;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (ir_ff[31:30] == FMT_MEM) begin
               ea_in     = sum[AW-1:0];
               ram_raddr = sum[AW-1:0];
               rf_ra     = ir_ff[29:25];
               state_in  = (ir_ff[24:19] == OP3_STORE) ? ST_STRD : ST_LOAD;
            end else begin
               case (ir_ff[24:19])
                  OP3_ADD: begin
                     res         = sum;
                     rsp_kind_in = KIND_ADD;
                  end
                  OP3_OR: begin
                     res         = op_a | op_b;
                     rsp_kind_in = KIND_OR;
                  end
                  OP3_SUB: begin
                     res         = diff;
                     rsp_kind_in = KIND_SUB;
                  end
                  OP3_SUBCC: begin
                     res         = diff;
                     cc_in       = {diff[31], (diff == '0), ovf, (op_a < op_b)};
                     rsp_kind_in = KIND_SUBCC;
                  end
                  default: begin
                     res         = op_a << op_b[4:0];
                     rsp_kind_in = KIND_SLL;
                  end
               endcase
               rf_we        = (ir_ff[29:25] != 5'd0);
               rf_wdata     = res;
               rsp_data_in  = res;
               rsp_valid_in = 1'b1;
            end
         end
         ST_LOAD: begin
            rf_we        = (ir_ff[29:25] != 5'd0);
            rf_wdata     = ram_rdata_ff;
            rsp_data_in  = ram_rdata_ff;
            rsp_kind_in  = KIND_LOAD;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_STRD: begin
            ram_we       = 1'b1;
            ram_waddr    = ea_ff;
            ram_wdata    = op_a;
            rsp_data_in  = op_a;
            rsp_kind_in  = KIND_STORE;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rf_we) begin
         rf_vld_in[rf_waddr] = 1'b1;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         cc_ff        <= '0;
         halt_ff      <= 1'b0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         cc_ff        <= cc_in;
         halt_ff      <= halt_in;
         rf_vld_ff    <= rf_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ir_ff       <= ir_in;
      ea_ff       <= ea_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   // main memory
   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_ff[ram_waddr] <= ram_wdata;
      end
      ram_rdata_ff <= ram_ff[ram_raddr];
   end

   // register file, two read ports
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[rf_waddr] <= rf_wdata;
      end
      rfa_ff     <= rf_ff[rf_ra];
      rfb_ff     <= rf_ff[rf_rb];
      rfa_vld_ff <= rf_vld_ff[rf_ra];
      rfb_vld_ff <= rf_vld_ff[rf_rb];
   end

endmodule

// ===== sv/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker
// port-level checks of the subset core command and result channels
// ----------------------------------------------------------------------------
`include "sparc_subset_core_assert.svh"

module ssc_checker
   import ssc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [3:0] rsp_instr_kind,
   input logic       rsp_halted
);

   logic accepted;
   logic idle_quiet;
   logic halt_rsp;

   assign accepted   = start && !busy;
   assign idle_quiet = !busy && !start;
   assign halt_rsp   = rsp_valid && (rsp_instr_kind == KIND_HALT);

   `SSC_ASSERT_NEXT(a_accept_progress, clock, reset, accepted, busy || rsp_valid, "lost accept")
   `SSC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")
   `SSC_ASSERT_NEXT(a_no_spurious, clock, reset, idle_quiet, !rsp_valid, "strobe without work")
   `SSC_ASSERT_NEXT(a_halt_sticky, clock, reset, rsp_halted, rsp_halted, "halt flag dropped")
   `SSC_ASSERT_NOW(a_halt_kind, clock, reset, halt_rsp, rsp_halted, "halt kind without flag")

endmodule

bind sparc_subset_core ssc_checker u_ssc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_instr_kind (rsp_instr_kind),
   .rsp_halted     (rsp_halted)
);
